[sv/fpsqrt_pkg.sv]
// ----------------------------------------------------------------------------
// fpsqrt_pkg
// shared widths and constants for the fixed-point square root pipeline
// ----------------------------------------------------------------------------
package fpsqrt_pkg;

    // payload widths of the two channels
    localparam int RADICAND_W = 32;
    localparam int ROOT_W     = 24;

    // radicand bits brought down per digit step
    localparam int PAIR_W = 2;

    // low bits of the trial value 4r+1
    localparam logic [PAIR_W-1:0] TRIAL_LSB = 2'b01;

    typedef logic [RADICAND_W-1:0] t_radicand;
    typedef logic [ROOT_W-1:0]     t_root;

endpackage

[sv/fpsqrt_if.sv]
// ----------------------------------------------------------------------------
// fpsqrt channel interfaces
// valid/ready channels for radicand input and root output
// ----------------------------------------------------------------------------
interface fpsqrt_in_if;
    import fpsqrt_pkg::*;

    logic      valid;
    logic      ready;
    t_radicand radicand;

    modport source (output valid, output radicand, input ready);
    modport sink   (input valid, input radicand, output ready);
endinterface

interface fpsqrt_out_if;
    import fpsqrt_pkg::*;

    logic  valid;
    logic  ready;
    t_root root;

    modport source (output valid, output root, input ready);
    modport sink   (input valid, input root, output ready);
endinterface

[sv/fpsqrt_step.sv]
// ----------------------------------------------------------------------------
// fpsqrt_step
// one restoring digit step with its output register and valid bit
// ----------------------------------------------------------------------------
module fpsqrt_step #(
    parameter int QW = 16,
    parameter int RW = 18,
    parameter int VW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [RW-1:0] i_rem,
    input  logic [QW-1:0] i_root,
    input  logic [VW-1:0] i_val,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [RW-1:0] o_rem,
    output logic [QW-1:0] o_root,
    output logic [VW-1:0] o_val
);
    import fpsqrt_pkg::*;

    logic          r_valid;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_root;
    logic [VW-1:0] r_val;

    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic          fits;
    logic [RW-1:0] n_rem;
    logic [QW-1:0] n_root;
    logic [VW-1:0] n_val;
    logic          load;

    // bring down the next pair and trial-subtract 4r+1
    always_comb begin
        cur    = {i_rem[RW-PAIR_W-1:0], i_val[VW-1 -: PAIR_W]};
        trial  = {i_root, TRIAL_LSB};
        fits   = (cur >= trial);
        n_rem  = fits ? (cur - trial) : cur;
        n_root = {i_root[QW-2:0], fits};
        n_val  = {i_val[VW-PAIR_W-1:0], {PAIR_W{1'b0}}};
    end

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_val  <= n_val;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_val   = r_val;

endmodule

[sv/fixed_point_square_root.sv]
// ----------------------------------------------------------------------------
// fixed_point_square_root
// pipelined digit-by-digit square root of an unsigned fixed-point value
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload           | transfer when
//  ---------+-----+-------------------+-------------------------
//  i_in     | in  | radicand [31:0]   | i_in.valid && i_in.ready
//  o_out    | out | root [23:0]       | o_out.valid && o_out.ready
//
//  STEPS = TOTAL_BITS - IB/2 (24 by default), IB being INT_BITS capped at TOTAL_BITS
//  one transfer per cycle while o_out is ready: one input register then one
//  register stage per root digit, each holding a single trial subtract
//  every stage has its own valid bit and takes a new item once its own
//  content moves on, so bubbles close up while the output is stalled
//  synchronous active-low reset clears the valid bits only
//
module fixed_point_square_root #(
    parameter int TOTAL_BITS = 32,
    parameter int INT_BITS   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fpsqrt_in_if.sink      i_in,
    fpsqrt_out_if.source   o_out
);
    import fpsqrt_pkg::*;

    // integer bits are capped at the total width
    localparam int IB    = (INT_BITS > TOTAL_BITS) ? TOTAL_BITS : INT_BITS;
    localparam int FRAC  = TOTAL_BITS - IB;
    localparam int STEPS = TOTAL_BITS - IB / 2;
    // root width, remainder width and the width of radicand << FRAC
    localparam int QW    = STEPS;
    localparam int RW    = STEPS + PAIR_W;
    localparam int VW    = PAIR_W * STEPS;

    // stage k carries the state entering digit step k
    logic          s_valid [0:STEPS];
    logic          s_ready [0:STEPS];
    logic [RW-1:0] s_rem   [0:STEPS];
    logic [QW-1:0] s_root  [0:STEPS];
    logic [VW-1:0] s_val   [0:STEPS];

    // input register: aligned radicand, empty remainder and root
    logic          r_in_valid;
    logic [VW-1:0] r_in_val;
    logic [VW-1:0] n_in_val;

    // only the low TOTAL_BITS of the radicand take part
    assign n_in_val   = VW'(i_in.radicand[TOTAL_BITS-1:0]) << FRAC;
    assign i_in.ready = !r_in_valid || s_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_val <= n_in_val;
        end
    end

    assign s_valid[0] = r_in_valid;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;
    assign s_val[0]   = r_in_val;

    // one registered digit step per root bit, most significant first
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        fpsqrt_step #(
            .QW (QW),
            .RW (RW),
            .VW (VW)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_rem   (s_rem[k]),
            .i_root  (s_root[k]),
            .i_val   (s_val[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_root  (s_root[k+1]),
            .o_val   (s_val[k+1])
        );
    end

    // last stage register drives the output; root fits or keeps its low bits
    assign s_ready[STEPS] = o_out.ready;
    assign o_out.valid    = s_valid[STEPS];
    assign o_out.root     = ROOT_W'(s_root[STEPS]);

    // an empty input register always takes a transfer
    a_in_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("input refused with empty input register");

    // a free output frees the whole chain back to the input
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready)
        else $error("ready chain broken while output drains");

    // an accepted radicand is held in the input register next cycle
    a_in_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_in_valid)
        else $error("accepted radicand lost at input register");

    // a stalled first digit step keeps the input register from losing its item
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !s_ready[0]) |=> (r_in_valid && $stable(r_in_val)))
        else $error("input register changed while stalled");

endmodule
